// ===== sv/q24_pkg.sv =====
// Shared types, mode codes and defaults for the Q24.8 arithmetic unit.
package q24_pkg;

  localparam int DATA_W        = 32;
  localparam int DEF_FRAC_BITS = 8;
  localparam int DEF_WORD_BITS = 32;

  // Operation codes carried by the mode field.
  typedef enum logic [3:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_MUL = 4'd2,
    MODE_DIV = 4'd3,
    MODE_GT  = 4'd4,
    MODE_LT  = 4'd5,
    MODE_GE  = 4'd6,
    MODE_LE  = 4'd7,
    MODE_EQ  = 4'd8,
    MODE_NE  = 4'd9,
    MODE_MIN = 4'd10,
    MODE_MAX = 4'd11,
    MODE_INC = 4'd12,
    MODE_DEC = 4'd13,
    MODE_I2F = 4'd14
  } mode_t;

  // Per-item side information that rides along the long arithmetic paths.
  typedef struct packed {
    logic [3:0]        mode;
    logic [DATA_W-1:0] res;
    logic              truth;
    logic              ovf;
    logic              neg;
    logic              a_pos;
    logic              a_neg;
    logic              b_zero;
  } side_t;

  // A saturated value together with its overflow flag.
  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

endpackage

// ===== sv/q24_front.sv =====
// Front stage: operations outside mul and div, magnitudes and signs for mul and div.
module q24_front import q24_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int EFF       = DEF_WORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_v,
  input  logic [3:0]               mode,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     v_r,
  output side_t                    side_r,
  output logic [EFF-1:0]           ma_r,
  output logic [EFF-1:0]           mb_r
);

  localparam logic signed [63:0] MAXV = (64'sd1 <<< (EFF - 1)) - 64'sd1;
  localparam logic signed [63:0] MINV = -MAXV - 64'sd1;

  // Clamp a wide signed value to the word range.
  function automatic sat_t sat_s(input logic signed [63:0] x);
    sat_t s;
    s.ovf = 1'b0;
    s.val = x[DATA_W-1:0];
    if (x > MAXV) begin
      s.ovf = 1'b1;
      s.val = MAXV[DATA_W-1:0];
    end else if (x < MINV) begin
      s.ovf = 1'b1;
      s.val = MINV[DATA_W-1:0];
    end
    return s;
  endfunction

  logic signed [63:0] a64, b64;
  logic [DATA_W-1:0]  abs_a, abs_b;
  sat_t               sat;
  side_t              side_nxt;

  assign a64   = 64'(a);
  assign b64   = 64'(b);
  assign abs_a = a[DATA_W-1] ? -a : a;
  assign abs_b = b[DATA_W-1] ? -b : b;

  // Results of all operations that bypass the multiplier and the divider.
  always_comb begin
    side_nxt        = '0;
    side_nxt.mode   = mode;
    side_nxt.neg    = a[DATA_W-1] ^ b[DATA_W-1];
    side_nxt.a_pos  = (a > 0);
    side_nxt.a_neg  = a[DATA_W-1];
    side_nxt.b_zero = (b == 0);
    sat             = '0;
    case (mode)
      MODE_ADD: sat = sat_s(a64 + b64);
      MODE_SUB: sat = sat_s(a64 - b64);
      MODE_INC: sat = sat_s(a64 + 64'sd1);
      MODE_DEC: sat = sat_s(a64 - 64'sd1);
      MODE_I2F: sat = sat_s(a64 <<< FRAC_BITS);
      MODE_MIN: sat.val = (a < b) ? a : b;
      MODE_MAX: sat.val = (a > b) ? a : b;
      MODE_GT:  side_nxt.truth = (a > b);
      MODE_LT:  side_nxt.truth = (a < b);
      MODE_GE:  side_nxt.truth = (a >= b);
      MODE_LE:  side_nxt.truth = (a <= b);
      MODE_EQ:  side_nxt.truth = (a == b);
      MODE_NE:  side_nxt.truth = (a != b);
      default:  sat = '0;
    endcase
    side_nxt.res = sat.val;
    side_nxt.ovf = sat.ovf;
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else        v_r <= in_v;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    ma_r   <= abs_a[EFF-1:0];
    mb_r   <= abs_b[EFF-1:0];
  end

endmodule

// ===== sv/q24_mul.sv =====
// Two-stage unsigned multiplier with round-half-up on the fraction bits.
module q24_mul #(
  parameter int MW        = 32,
  parameter int FRAC_BITS = 8,
  parameter int TW        = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_v,
  input  logic [MW-1:0]   ma,
  input  logic [MW-1:0]   mb,
  input  logic [TW-1:0]   in_tag,
  output logic            out_v,
  output logic [2*MW-1:0] q,
  output logic [TW-1:0]   out_tag
);

  localparam logic [2*MW-1:0] HALF = (2*MW)'(1) << (FRAC_BITS - 1);

  logic            v1_r, v2_r;
  logic [2*MW-1:0] prod_r, q_r;
  logic [TW-1:0]   tag1_r, tag2_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  // Product, then rounded shift.
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    tag1_r <= in_tag;
    q_r    <= (prod_r + HALF) >> FRAC_BITS;
    tag2_r <= tag1_r;
  end

  assign out_v   = v2_r;
  assign q       = q_r;
  assign out_tag = tag2_r;

endmodule

// ===== sv/q24_div.sv =====
// Restoring divider, one quotient bit per pipeline stage.
module q24_div #(
  parameter int NB = 40,
  parameter int DB = 32,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  input  logic [TW-1:0] in_tag,
  output logic          out_v,
  output logic [NB-1:0] q,
  output logic [DB-1:0] rem,
  output logic [DB-1:0] out_den,
  output logic [TW-1:0] out_tag
);

  // Stage views: index 0 is the input, index k+1 the register of stage k.
  logic          s_v   [NB+1];
  logic [DB-1:0] s_rem [NB+1];
  logic [NB-1:0] s_qn  [NB+1];
  logic [DB-1:0] s_den [NB+1];
  logic [TW-1:0] s_tag [NB+1];

  logic          v_r   [NB];
  logic [DB-1:0] rem_r [NB];
  logic [NB-1:0] qn_r  [NB];
  logic [DB-1:0] den_r [NB];
  logic [TW-1:0] tag_r [NB];

  assign s_v[0]   = in_v;
  assign s_rem[0] = '0;
  assign s_qn[0]  = num;
  assign s_den[0] = den;
  assign s_tag[0] = in_tag;

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [DB:0]   t;
    logic          ge;
    logic [DB-1:0] rem_nxt;
    logic [NB-1:0] qn_nxt;

    // Bring down the next numerator bit and try one subtraction.
    always_comb begin
      t       = {s_rem[k], s_qn[k][NB-1]};
      ge      = (t >= {1'b0, s_den[k]});
      rem_nxt = ge ? DB'(t - {1'b0, s_den[k]}) : t[DB-1:0];
      qn_nxt  = {s_qn[k][NB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else        v_r[k] <= s_v[k];
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      qn_r[k]  <= qn_nxt;
      den_r[k] <= s_den[k];
      tag_r[k] <= s_tag[k];
    end

    assign s_v[k+1]   = v_r[k];
    assign s_rem[k+1] = rem_r[k];
    assign s_qn[k+1]  = qn_r[k];
    assign s_den[k+1] = den_r[k];
    assign s_tag[k+1] = tag_r[k];
  end

  assign out_v   = s_v[NB];
  assign q       = s_qn[NB];
  assign rem     = s_rem[NB];
  assign out_den = s_den[NB];
  assign out_tag = s_tag[NB];

endmodule

// ===== sv/q24_8_fixed_point_alu.sv =====
// Top level of the pipelined Q24.8 arithmetic unit.
//
//   Channel | Ports                                 | Handshake
//   input   | in_mode, in_operand_a, in_operand_b   | start high while busy low
//   result  | out_result, out_truth, out_overflowed,| out_valid, one cycle,
//           | out_divide_by_zero                    | no backpressure
//
// One item enters per cycle. Each item passes the input register, the front
// stage, the multiplier stages, one divider stage per quotient bit (WORD_BITS
// capped at 32, plus FRAC_BITS) and the output register; every mode runs this
// path, so results leave in order. Reset clears only the valid bits.
// busy is held low: the pipeline never stalls.
module q24_8_fixed_point_alu import q24_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [3:0]               in_mode,
  input  logic signed [DATA_W-1:0] in_operand_a,
  input  logic signed [DATA_W-1:0] in_operand_b,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_result,
  output logic                     out_truth,
  output logic                     out_overflowed,
  output logic                     out_divide_by_zero
);

  localparam int EFF  = (WORD_BITS > DATA_W) ? DATA_W : WORD_BITS;
  localparam int SH   = DATA_W - EFF;
  localparam int NB   = EFF + FRAC_BITS;
  localparam int SW   = $bits(side_t);
  localparam int MTW  = NB + EFF + SW;
  localparam int DTW  = 2 * EFF + SW;
  localparam logic [63:0] MAXP = (64'd1 << (EFF - 1)) - 64'd1;
  localparam logic [63:0] MAXN = 64'd1 << (EFF - 1);
  localparam logic [63:0] MINW = -MAXN;

  // Clamp a magnitude with a sign to the word range.
  function automatic sat_t sat_u(input logic [63:0] mag, input logic neg);
    sat_t s;
    logic [63:0] nv;
    nv    = -mag;
    s.ovf = 1'b0;
    if (!neg) begin
      if (mag > MAXP) begin
        s.ovf = 1'b1;
        s.val = MAXP[DATA_W-1:0];
      end else begin
        s.val = mag[DATA_W-1:0];
      end
    end else begin
      if (mag > MAXN) begin
        s.ovf = 1'b1;
        s.val = MINW[DATA_W-1:0];
      end else begin
        s.val = nv[DATA_W-1:0];
      end
    end
    return s;
  endfunction

  // Input register, operands sign-extended from the effective word width.
  logic                     v0_r;
  logic [3:0]               mode0_r;
  logic signed [DATA_W-1:0] a0_r, b0_r;
  logic signed [DATA_W-1:0] a_sh, b_sh;

  assign busy = 1'b0;
  assign a_sh = in_operand_a <<< SH;
  assign b_sh = in_operand_b <<< SH;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    mode0_r <= in_mode;
    a0_r    <= a_sh >>> SH;
    b0_r    <= b_sh >>> SH;
  end

  // Operations outside mul and div, and operand preparation.
  logic           v1;
  side_t          side1;
  logic [EFF-1:0] ma1, mb1;

  q24_front #(.FRAC_BITS(FRAC_BITS), .EFF(EFF)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (v0_r),
    .mode   (mode0_r),
    .a      (a0_r),
    .b      (b0_r),
    .v_r    (v1),
    .side_r (side1),
    .ma_r   (ma1),
    .mb_r   (mb1)
  );

  // Multiplier; the divider inputs ride along.
  logic             v2;
  logic [2*EFF-1:0] mq2;
  logic [MTW-1:0]   mtag2;
  logic [NB-1:0]    num2;
  logic [EFF-1:0]   den2;
  side_t            side2;

  q24_mul #(.MW(EFF), .FRAC_BITS(FRAC_BITS), .TW(MTW)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (v1),
    .ma      (ma1),
    .mb      (mb1),
    .in_tag  ({NB'(ma1) << FRAC_BITS, mb1, side1}),
    .out_v   (v2),
    .q       (mq2),
    .out_tag (mtag2)
  );

  assign {num2, den2, side2} = mtag2;

  // Divider; the multiplier result and side information ride along.
  logic             v3;
  logic [NB-1:0]    dq3;
  logic [EFF-1:0]   rem3, den3;
  logic [DTW-1:0]   dtag3;
  logic [2*EFF-1:0] mq3;
  side_t            side3;

  q24_div #(.NB(NB), .DB(EFF), .TW(DTW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (v2),
    .num     (num2),
    .den     (den2),
    .in_tag  ({mq2, side2}),
    .out_v   (v3),
    .q       (dq3),
    .rem     (rem3),
    .out_den (den3),
    .out_tag (dtag3)
  );

  assign {mq3, side3} = dtag3;

  // Final selection: round the quotient, saturate, pick by mode.
  logic              rnd;
  logic [63:0]       dq_rnd;
  sat_t              fin;
  logic              truth_nxt, dz_nxt;

  assign rnd    = ({rem3, 1'b0} >= {1'b0, den3});
  assign dq_rnd = 64'(dq3) + 64'(rnd);

  always_comb begin
    fin       = '0;
    truth_nxt = side3.truth;
    dz_nxt    = 1'b0;
    case (side3.mode)
      MODE_MUL: fin = sat_u(64'(mq3), side3.neg);
      MODE_DIV: begin
        if (side3.b_zero) begin
          dz_nxt = 1'b1;
          if (side3.a_pos) begin
            fin.ovf = 1'b1;
            fin.val = MAXP[DATA_W-1:0];
          end else if (side3.a_neg) begin
            fin.ovf = 1'b1;
            fin.val = MINW[DATA_W-1:0];
          end
        end else begin
          fin = sat_u(dq_rnd, side3.neg);
        end
      end
      default: begin
        fin.val = side3.res;
        fin.ovf = side3.ovf;
      end
    endcase
  end

  // Output register.
  logic              out_v_r;
  logic [DATA_W-1:0] res_r;
  logic              truth_r, ovf_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else        out_v_r <= v3;
  end

  always_ff @(posedge clk) begin
    res_r   <= fin.val;
    truth_r <= truth_nxt;
    ovf_r   <= fin.ovf;
    dz_r    <= dz_nxt;
  end

  assign out_valid          = out_v_r;
  assign out_result         = res_r;
  assign out_truth          = truth_r;
  assign out_overflowed     = ovf_r;
  assign out_divide_by_zero = dz_r;

endmodule

// ===== sv/q24_checker.sv =====
// Port-level checks for the arithmetic unit, bound to the top level.
module q24_checker import q24_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic signed [DATA_W-1:0] out_result,
  input logic                     out_truth,
  input logic                     out_overflowed,
  input logic                     out_divide_by_zero
);

  localparam int EFF = (WORD_BITS > DATA_W) ? DATA_W : WORD_BITS;
  localparam int LAT = EFF + FRAC_BITS + 5;
  localparam logic signed [DATA_W-1:0] WMAX = DATA_W'((64'sd1 <<< (EFF - 1)) - 64'sd1);
  localparam logic signed [DATA_W-1:0] WMIN = -WMAX - 1;

  // Every accepted item produces its result strobe after the delay LAT.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("missing result strobe");

  // Reset leaves no result in flight.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // A saturated result sits on one of the word bounds.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflowed) |-> (out_result == WMAX || out_result == WMIN))
    else $error("overflowed result not at a bound");

  // A true comparison outcome comes with a zero result and no error flags.
  a_truth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_truth) |->
      (out_result == 0 && !out_overflowed && !out_divide_by_zero))
    else $error("comparison item with nonzero result");

endmodule

bind q24_8_fixed_point_alu q24_checker #(
  .FRAC_BITS(FRAC_BITS),
  .WORD_BITS(WORD_BITS)
) u_q24_checker (.*);
